/* src/aebdc_pkg.sv */
// Package for the audio elastic buffer: ring geometry, field widths, register
// indexes, action codes and the command/status structs between controller and datapath.
// No dependencies.
package aebdc_pkg;

    localparam int RING_DEPTH = 1024;
    localparam int IDX_W      = $clog2(RING_DEPTH);

    localparam int SMP_W      = 16;
    localparam int FRAME_W    = 4 * SMP_W;
    localparam int FILL_W     = 10;
    localparam int OPT_W      = 10;
    localparam int GAIN_W     = 16;
    localparam int MAXA_W     = 15;
    localparam int ADJ_W      = 16;
    localparam int PHASE_W    = 16;
    localparam int SUM_W      = PHASE_W + 3;
    localparam int ERR_W      = ((IDX_W > OPT_W) ? IDX_W : OPT_W) + 1;
    localparam int PROD_W     = ERR_W + GAIN_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_OPTIMAL_FILL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADJUST_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ADJUST   = 2'd2;

    localparam logic [OPT_W-1:0]  OPT_FILL_RST   = 10'd512;
    localparam logic [GAIN_W-1:0] ADJ_GAIN_RST   = 16'd16;
    localparam logic [MAXA_W-1:0] MAX_ADJUST_RST = 15'd655;

    localparam logic [SUM_W-1:0]  PHASE_ONE  = SUM_W'(65536);
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(RING_DEPTH - 1);
    localparam logic [IDX_W:0]    DEPTH_EXT  = (IDX_W + 1)'(RING_DEPTH);

    typedef logic signed [SMP_W-1:0] sample_t;
    typedef logic [IDX_W-1:0]        idx_t;

    typedef enum logic [1:0] {
        ACT_PUSH    = 2'd0,
        ACT_PULL    = 2'd1,
        ACT_RECOMP  = 2'd2,
        ACT_FLUSH   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLAMP,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic clamp;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        action_t action;
    } stat_t;

    // Ring successor with wrap at the last slot.
    function automatic idx_t next_slot(input idx_t i);
        return (i == LAST_IDX) ? '0 : idx_t'(i + 1'b1);
    endfunction

    // Frames held: (write - read) modulo the ring depth.
    function automatic idx_t held_frames(input idx_t w, input idx_t r);
        logic [IDX_W:0] wrap;
        wrap = {1'b0, w} + DEPTH_EXT - {1'b0, r};
        return (w >= r) ? idx_t'(w - r) : wrap[IDX_W-1:0];
    endfunction

endpackage

/* src/aebdc_req_if.sv */
// Request channel of the elastic buffer: action code and the four samples of a frame.
// Depends on aebdc_pkg.
interface aebdc_req_if;
    logic                valid;
    logic                ready;
    aebdc_pkg::action_t  action;
    aebdc_pkg::sample_t  in_ch0;
    aebdc_pkg::sample_t  in_ch1;
    aebdc_pkg::sample_t  in_ch2;
    aebdc_pkg::sample_t  in_ch3;

    modport source (output valid, action, in_ch0, in_ch1, in_ch2, in_ch3, input ready);
    modport sink   (input valid, action, in_ch0, in_ch1, in_ch2, in_ch3, output ready);
endinterface

/* src/aebdc_rsp_if.sv */
// Response channel of the elastic buffer: pulled frame, flags, fill and adjustment.
// Depends on aebdc_pkg.
interface aebdc_rsp_if;
    logic                               valid;
    logic                               ready;
    aebdc_pkg::sample_t                 out_ch0;
    aebdc_pkg::sample_t                 out_ch1;
    aebdc_pkg::sample_t                 out_ch2;
    aebdc_pkg::sample_t                 out_ch3;
    logic                               underrun;
    logic                               dropped;
    logic [aebdc_pkg::FILL_W-1:0]       fill_level;
    logic signed [aebdc_pkg::ADJ_W-1:0] speed_adjust;

    modport source (output valid, out_ch0, out_ch1, out_ch2, out_ch3, underrun, dropped,
                    fill_level, speed_adjust, input ready);
    modport sink   (input valid, out_ch0, out_ch1, out_ch2, out_ch3, underrun, dropped,
                    fill_level, speed_adjust, output ready);
endinterface

/* src/aebdc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module aebdc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/aebdc_ctrl.sv */
// Sequencing state machine of the elastic buffer and the result valid flag.
// Depends on aebdc_pkg.
module aebdc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  aebdc_pkg::stat_t stat,
    output aebdc_pkg::cmd_t  cmd
);
    import aebdc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = (stat.action == ACT_RECOMP) ? ST_CLAMP : ST_LOAD;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // Wait here only while the previous result is still unclaimed.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* src/aebdc_dp.sv */
// Datapath of the elastic buffer: ring indices, frame store, phase accumulator,
// adjustment multiply and clamp, configuration registers and result register.
// Depends on aebdc_pkg and aebdc_ram.
module aebdc_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [aebdc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aebdc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  aebdc_pkg::action_t                  in_action,
    input  aebdc_pkg::sample_t                  in_ch0,
    input  aebdc_pkg::sample_t                  in_ch1,
    input  aebdc_pkg::sample_t                  in_ch2,
    input  aebdc_pkg::sample_t                  in_ch3,
    input  aebdc_pkg::cmd_t                     cmd,
    output aebdc_pkg::stat_t                    stat,
    output aebdc_pkg::sample_t                  out_ch0,
    output aebdc_pkg::sample_t                  out_ch1,
    output aebdc_pkg::sample_t                  out_ch2,
    output aebdc_pkg::sample_t                  out_ch3,
    output logic                                underrun,
    output logic                                dropped,
    output logic [aebdc_pkg::FILL_W-1:0]        fill_level,
    output logic signed [aebdc_pkg::ADJ_W-1:0]  speed_adjust
);
    import aebdc_pkg::*;

    // Configuration.
    logic [OPT_W-1:0]  optimal_fill_reg;
    logic [GAIN_W-1:0] adjust_gain_reg;
    logic [MAXA_W-1:0] max_adjust_reg;

    // Control state.
    idx_t                     write_index_reg, write_index_next;
    idx_t                     read_index_reg, read_index_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic signed [ADJ_W-1:0]  adjust_reg, adjust_next;

    // Captured item and per-item scratch.
    action_t                  action_reg;
    logic [FRAME_W-1:0]       frame_reg;
    logic                     under_reg, under_next;
    logic                     drop_reg, drop_next;
    logic                     frame_ok_reg, frame_ok_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     at_start_reg;

    // Result register.
    logic [FRAME_W-1:0]       res_frame_reg;
    logic                     res_under_reg;
    logic                     res_drop_reg;
    logic [FILL_W-1:0]        res_fill_reg;
    logic signed [ADJ_W-1:0]  res_adjust_reg;

    // Memory port signals.
    logic                     ram_wr_en;
    logic                     ram_rd_en;
    logic [FRAME_W-1:0]       ram_rd_data;

    idx_t                     held;
    idx_t                     rd_step1;
    idx_t                     rd_step2;
    logic [SUM_W-1:0]         phase_sum;
    logic [1:0]               units;
    logic signed [ERR_W-1:0]  fill_err;
    logic signed [PROD_W-1:0] prod_calc;
    logic signed [PROD_W-1:0] limit;
    logic signed [PROD_W-1:0] clamped;
    logic [IDX_W+FILL_W-1:0]  fill_wide;

    assign held      = held_frames(write_index_reg, read_index_reg);
    assign rd_step1  = next_slot(read_index_reg);
    assign rd_step2  = next_slot(rd_step1);

    // Phase plus one whole unit plus the signed adjustment; never negative.
    assign phase_sum = SUM_W'(phase_reg) + PHASE_ONE + SUM_W'(adjust_reg);
    assign units     = phase_sum[PHASE_W+1:PHASE_W];

    assign fill_err  = signed'(ERR_W'(held)) - signed'(ERR_W'(optimal_fill_reg));
    assign prod_calc = PROD_W'(fill_err) * signed'(PROD_W'(adjust_gain_reg));

    assign limit     = signed'(PROD_W'(max_adjust_reg));

    always_comb
    begin
        priority if (prod_reg > limit)
        begin
            clamped = limit;
        end
        else if (prod_reg < -limit)
        begin
            clamped = -limit;
        end
        else
        begin
            clamped = prod_reg;
        end
    end

    always_comb
    begin
        write_index_next = write_index_reg;
        read_index_next  = read_index_reg;
        phase_next       = phase_reg;
        adjust_next      = adjust_reg;
        under_next       = 1'b0;
        drop_next        = 1'b0;
        frame_ok_next    = 1'b0;
        ram_wr_en        = 1'b0;
        ram_rd_en        = 1'b0;
        if (cmd.exec)
        begin
            unique case (action_reg)
                ACT_PUSH:
                begin
                    if (next_slot(write_index_reg) == read_index_reg)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        ram_wr_en        = 1'b1;
                        write_index_next = next_slot(write_index_reg);
                    end
                end
                ACT_PULL:
                begin
                    if (read_index_reg == write_index_reg)
                    begin
                        under_next = 1'b1;
                    end
                    else
                    begin
                        ram_rd_en     = 1'b1;
                        frame_ok_next = 1'b1;
                        phase_next    = phase_sum[PHASE_W-1:0];
                        // Up to two whole units; the read index stops at the write index.
                        if (units != 2'd0)
                        begin
                            read_index_next = rd_step1;
                            if (units[1] && rd_step1 != write_index_reg)
                            begin
                                read_index_next = rd_step2;
                            end
                        end
                    end
                end
                ACT_RECOMP:
                begin
                end
                ACT_FLUSH:
                begin
                    write_index_next = '0;
                    read_index_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.clamp)
        begin
            adjust_next = at_start_reg ? '0 : ADJ_W'(clamped);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            optimal_fill_reg <= OPT_FILL_RST;
            adjust_gain_reg  <= ADJ_GAIN_RST;
            max_adjust_reg   <= MAX_ADJUST_RST;
            write_index_reg  <= '0;
            read_index_reg   <= '0;
            phase_reg        <= '0;
            adjust_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_OPTIMAL_FILL: optimal_fill_reg <= cfg_wdata[OPT_W-1:0];
                    REG_ADJUST_GAIN:  adjust_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                    REG_MAX_ADJUST:   max_adjust_reg   <= cfg_wdata[MAXA_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            write_index_reg <= write_index_next;
            read_index_reg  <= read_index_next;
            phase_reg       <= phase_next;
            adjust_reg      <= adjust_next;
        end
    end

    assign fill_wide = {{FILL_W{1'b0}}, held};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= in_action;
            frame_reg  <= {in_ch3, in_ch2, in_ch1, in_ch0};
        end
        if (cmd.exec)
        begin
            under_reg    <= under_next;
            drop_reg     <= drop_next;
            frame_ok_reg <= frame_ok_next;
            prod_reg     <= prod_calc;
            at_start_reg <= (write_index_reg == '0) && (read_index_reg == '0);
        end
        if (cmd.load_out)
        begin
            res_frame_reg  <= frame_ok_reg ? ram_rd_data : '0;
            res_under_reg  <= under_reg;
            res_drop_reg   <= drop_reg;
            res_fill_reg   <= fill_wide[FILL_W-1:0];
            res_adjust_reg <= adjust_reg;
        end
    end

    aebdc_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (RING_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (write_index_reg),
        .wr_data (frame_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (read_index_reg),
        .rd_data (ram_rd_data)
    );

    assign stat.action  = action_reg;
    assign out_ch0      = res_frame_reg[SMP_W-1:0];
    assign out_ch1      = res_frame_reg[2*SMP_W-1:SMP_W];
    assign out_ch2      = res_frame_reg[3*SMP_W-1:2*SMP_W];
    assign out_ch3      = res_frame_reg[4*SMP_W-1:3*SMP_W];
    assign underrun     = res_under_reg;
    assign dropped      = res_drop_reg;
    assign fill_level   = res_fill_reg;
    assign speed_adjust = res_adjust_reg;

endmodule

/* src/audio_elastic_buffer_drift_comp.sv */
// Top level of the audio elastic buffer with drift compensation.
// Depends on aebdc_pkg, aebdc_req_if, aebdc_rsp_if, aebdc_ctrl and aebdc_dp.
//
// Usage:
//   The req channel carries one item per handshake: an action code (push,
//   pull, recompute, flush) and a four-channel frame that only push uses.
//   Every item yields exactly one result item on the rsp channel, carrying
//   the pulled frame (zero unless a pull succeeded), the underrun and dropped
//   flags, the fill level after the item and the current speed adjustment.
//   From acceptance an item passes through the execute and load states, and
//   recompute also through a clamp state, as its product is registered
//   before the clamp. The block works on one item at a time and takes no
//   new item until the last one is loaded; the frame store's single
//   registered read port and the multiply/clamp sequence set these states.
//   A finished result sits in an output register, so the next item is
//   accepted while it waits; if the receiver stalls longer, the block holds
//   the following result internally and stops taking items until it drains.
//   Reset clears both ring indices, the phase and the adjustment and loads
//   the register defaults; the frame store is not cleared, and no pull can
//   read an entry that was not written since the last flush.
//   Configuration writes apply on cfg_wr_en; the user keeps them to idle (not enforced).
module audio_elastic_buffer_drift_comp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [aebdc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [aebdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    aebdc_req_if.sink                         req,
    aebdc_rsp_if.source                       rsp
);
    import aebdc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    aebdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    aebdc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_action    (req.action),
        .in_ch0       (req.in_ch0),
        .in_ch1       (req.in_ch1),
        .in_ch2       (req.in_ch2),
        .in_ch3       (req.in_ch3),
        .cmd          (cmd),
        .stat         (stat),
        .out_ch0      (rsp.out_ch0),
        .out_ch1      (rsp.out_ch1),
        .out_ch2      (rsp.out_ch2),
        .out_ch3      (rsp.out_ch3),
        .underrun     (rsp.underrun),
        .dropped      (rsp.dropped),
        .fill_level   (rsp.fill_level),
        .speed_adjust (rsp.speed_adjust)
    );

endmodule
